[hw/rtl/erwc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erwc_pkg
// Shared types and constants for the event readiness window check.
// ----------------------------------------------------------------------------
package erwc_pkg;

  localparam int WINDOW     = 32;
  localparam int NUM_TYPES  = 4;
  localparam int TIME_WIDTH = 32;

  localparam int TYPE_W  = 2;
  localparam int IDX_W   = $clog2(WINDOW);
  localparam int POS_W   = $clog2(WINDOW + 1);
  localparam int LIM_AW  = 2 * TYPE_W;
  localparam int LIM_DEP = NUM_TYPES * NUM_TYPES;
  localparam int CNT_W   = 6;
  localparam int OPOS_W  = 5;
  localparam int WLIM_W  = 6;

  localparam logic [WLIM_W-1:0] WLIM_RESET = WLIM_W'(32);
  localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};
  localparam logic [OPOS_W-1:0] OPOS_MAX   = {OPOS_W{1'b1}};

  typedef enum logic {
    OP_LIMIT_WR = 1'b0,
    OP_EVENT    = 1'b1
  } erwc_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_DONE
  } erwc_state_t;

endpackage
`default_nettype wire

[hw/rtl/event_readiness_window_check.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// event_readiness_window_check
// Marks pending events that may run in parallel, using a type-pair limit table.
// ----------------------------------------------------------------------------
// usage:
//   in_ channel carries table writes (op 0) and events (op 1), valid/stall.
//   op 0 stores limit_value at (earlier_type, later_type), no result item.
//   op 1 gives exactly one result item on the out_ channel, valid/stall.
//   cfg_ channel writes window_limit (valid/ready), taken only while idle.
// flow:
//   an idle event at pass position p inside the window reads the p earlier
//   events one per cycle from the window memory, then the limit memory, and
//   compares each; its result is loaded into the output register once the
//   scan is flushed, and no new item is accepted until that result is loaded.
//   other events go straight to the result load; table writes leave the
//   block idle, so it can accept the next item right away.
// reset:
//   rst_n (sync, active low) clears pass position, ready count, window
//   limit (to 32) and the handshake state; memory contents are undefined.
// stall:
//   while out_stall is high the result holds; the next event is worked on
//   and waits for the output register, with in_stall high until it is loaded.
// ----------------------------------------------------------------------------
module event_readiness_window_check
  import erwc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_op,
  input  wire logic [TYPE_W-1:0]     in_earlier_type,
  input  wire logic [TYPE_W-1:0]     in_later_type,
  input  wire logic [TIME_WIDTH-1:0] in_limit_value,
  input  wire logic [TIME_WIDTH-1:0] in_event_time,
  input  wire logic [TYPE_W-1:0]     in_event_type,
  input  wire logic                  in_event_idle,
  input  wire logic                  in_last,

  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_ready_res,
  output logic [OPOS_W-1:0]          out_position,
  output logic                       out_within_window,
  output logic [CNT_W-1:0]           out_ready_count,
  output logic                       out_pass_end,

  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [WLIM_W-1:0]     cfg_window_limit
);

  // memories
  logic [TIME_WIDTH-1:0] limit_mem [LIM_DEP];
  logic [TIME_WIDTH-1:0] time_mem  [WINDOW];
  logic [TYPE_W-1:0]     type_mem  [WINDOW];

  erwc_state_t state_r, state_nxt;

  logic [WLIM_W-1:0]     wlim_r;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [CNT_W-1:0]      rtot_r, rtot_nxt;

  logic [TIME_WIDTH-1:0] ev_time_r;
  logic [TYPE_W-1:0]     ev_type_r;
  logic                  ev_last_r;
  logic                  ev_inside_r;
  logic                  ev_check_r;
  logic [POS_W-1:0]      ev_pos_r;

  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  v1_r, v2_r;
  logic [TIME_WIDTH-1:0] st_time_q;
  logic [TYPE_W-1:0]     st_type_q;
  logic [TIME_WIDTH-1:0] lim_q;
  logic [TIME_WIDTH-1:0] diff_r;
  logic                  ge_r;
  logic                  dep_r, dep_nxt;

  logic                  out_valid_r;
  logic                  out_ready_res_r;
  logic [OPOS_W-1:0]     out_position_r;
  logic                  out_within_window_r;
  logic [CNT_W-1:0]      out_ready_count_r;
  logic                  out_pass_end_r;

  logic                  in_acc;
  logic                  acc_limit, acc_event;
  logic                  pos_in_mem, in_win, check;
  logic                  rd_issue, scan_end, out_load;
  logic                  ev_ready;
  logic [CNT_W-1:0]      rcount;
  logic [IDX_W-1:0]      last_idx;

  assign in_acc     = in_valid && !in_stall;
  assign acc_limit  = in_acc && (in_op == OP_LIMIT_WR);
  assign acc_event  = in_acc && (in_op == OP_EVENT);
  assign pos_in_mem = pos_r < POS_W'(WINDOW);
  assign in_win     = pos_in_mem && ({{(POS_W > WLIM_W ? POS_W - WLIM_W : 0){1'b0}}, wlim_r}
                      > {{(WLIM_W > POS_W ? WLIM_W - POS_W : 0){1'b0}}, pos_r});
  assign check      = in_win && in_event_idle && (pos_r != '0);
  assign last_idx   = ev_pos_r[IDX_W-1:0] - IDX_W'(1);
  assign scan_end   = (idx_r == last_idx);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc_event) begin
          state_nxt = check ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!v1_r && !v2_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the control
  always_comb begin
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    rd_issue  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall  = 1'b0;
        cfg_ready = 1'b1;
      end
      S_SCAN:  rd_issue = 1'b1;
      S_FLUSH: ;
      S_DONE:  out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlim_r <= WLIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      wlim_r <= cfg_window_limit;
    end
  end

  // limit table
  always_ff @(posedge clk) begin
    if (acc_limit) begin
      limit_mem[{in_earlier_type, in_later_type}] <= in_limit_value;
    end
    if (v1_r) begin
      lim_q <= limit_mem[{st_type_q, ev_type_r}];
    end
  end

  // window store
  always_ff @(posedge clk) begin
    if (acc_event && pos_in_mem) begin
      time_mem[pos_r[IDX_W-1:0]] <= in_event_time;
      type_mem[pos_r[IDX_W-1:0]] <= in_event_type;
    end
    if (rd_issue) begin
      st_time_q <= time_mem[idx_r];
      st_type_q <= type_mem[idx_r];
    end
  end

  // event capture
  always_ff @(posedge clk) begin
    if (acc_event) begin
      ev_time_r   <= in_event_time;
      ev_type_r   <= in_event_type;
      ev_last_r   <= in_last;
      ev_inside_r <= in_win;
      ev_check_r  <= in_win && in_event_idle;
      ev_pos_r    <= pos_r;
    end
    if (v1_r) begin
      diff_r <= ev_time_r - st_time_q;
      ge_r   <= ev_time_r >= st_time_q;
    end
  end

  // scan pipeline
  always_comb begin
    idx_nxt = idx_r;
    dep_nxt = dep_r;
    if (acc_event) begin
      idx_nxt = '0;
      dep_nxt = 1'b0;
    end else begin
      if (rd_issue) begin
        idx_nxt = idx_r + IDX_W'(1);
      end
      if (v2_r && ge_r && (diff_r >= lim_q)) begin
        dep_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      dep_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      v1_r  <= rd_issue;
      v2_r  <= v1_r;
      dep_r <= dep_nxt;
    end
  end

  // pass counters and result
  assign ev_ready = ev_check_r && !dep_r;
  assign rcount   = (ev_ready && (rtot_r != CNT_MAX)) ? rtot_r + CNT_W'(1) : rtot_r;

  always_comb begin
    pos_nxt  = pos_r;
    rtot_nxt = rtot_r;
    if (out_load) begin
      rtot_nxt = ev_last_r ? '0 : rcount;
      if (ev_last_r) begin
        pos_nxt = '0;
      end else if (ev_pos_r < POS_W'(WINDOW)) begin
        pos_nxt = ev_pos_r + POS_W'(1);
      end else begin
        pos_nxt = ev_pos_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      rtot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      rtot_r <= rtot_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ready_res_r     <= ev_ready;
      out_position_r      <= (ev_pos_r < POS_W'(OPOS_MAX)) ? ev_pos_r[OPOS_W-1:0] : OPOS_MAX;
      out_within_window_r <= ev_inside_r;
      out_ready_count_r   <= rcount;
      out_pass_end_r      <= ev_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ready_res     = out_ready_res_r;
  assign out_position      = out_position_r;
  assign out_within_window = out_within_window_r;
  assign out_ready_count   = out_ready_count_r;
  assign out_pass_end      = out_pass_end_r;

`ifndef SYNTH
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result appeared outside the done state");

  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> $past(v1_r))
    else $error("compare stage without a limit read");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ({{(POS_W - IDX_W){1'b0}}, idx_r} < ev_pos_r))
    else $error("scan reads beyond earlier events");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(WINDOW))
    else $error("pass position beyond window");

  a_ready_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready_res_r) |-> out_within_window_r)
    else $error("ready event outside window");
`endif

endmodule
`default_nettype wire

[tb/erwc_readiness_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erwc_readiness_checker
// Watches the item, result and window-limit channels of the readiness window
// check, keeps its own copy of the limit table, the pass window and the
// window limit, predicts each result item and compares it field by field.
// ----------------------------------------------------------------------------
module erwc_readiness_checker
  import erwc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_op,
  input  logic [TYPE_W-1:0]     in_earlier_type,
  input  logic [TYPE_W-1:0]     in_later_type,
  input  logic [TIME_WIDTH-1:0] in_limit_value,
  input  logic [TIME_WIDTH-1:0] in_event_time,
  input  logic [TYPE_W-1:0]     in_event_type,
  input  logic                  in_event_idle,
  input  logic                  in_last,

  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_ready_res,
  input  logic [OPOS_W-1:0]     out_position,
  input  logic                  out_within_window,
  input  logic [CNT_W-1:0]      out_ready_count,
  input  logic                  out_pass_end,

  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [WLIM_W-1:0]     cfg_window_limit,

  output int                    fail_count,
  output int                    outstanding
);

  typedef struct packed {
    logic              ready;
    logic [OPOS_W-1:0] pos;
    logic              win;
    logic [CNT_W-1:0]  cnt;
    logic              pass_end;
  } readiness_t;

  logic [TIME_WIDTH-1:0] limit_tbl [LIM_DEP];
  logic [TIME_WIDTH-1:0] win_time  [WINDOW];
  logic [TYPE_W-1:0]     win_type  [WINDOW];
  int                    pass_pos;
  logic [CNT_W-1:0]      ready_tally;
  logic [WLIM_W-1:0]     win_limit;
  readiness_t            readiness_q [$];
  readiness_t            want;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, exp_val);
    fail_count++;
  endtask

  function automatic readiness_t predict_event(logic [TIME_WIDTH-1:0] t,
                                               logic [TYPE_W-1:0] ty,
                                               logic idle, logic lst);
    readiness_t r;
    int         eff;
    int         i;
    logic       indep;
    r   = '0;
    eff = (win_limit < WINDOW) ? int'(win_limit) : WINDOW;
    r.pos = (pass_pos < int'(OPOS_MAX)) ? OPOS_W'(pass_pos) : OPOS_MAX;
    if (pass_pos < WINDOW) begin
      if (pass_pos < eff) begin
        r.win = 1'b1;
        if (idle) begin
          indep = 1'b1;
          for (i = 0; i < pass_pos; i++) begin
            // a later time below the earlier one never makes it dependent
            if (t >= win_time[i] &&
                (t - win_time[i]) >= limit_tbl[{win_type[i], ty}])
              indep = 1'b0;
          end
          r.ready = indep;
        end
      end
      win_time[pass_pos] = t;
      win_type[pass_pos] = ty;
      pass_pos++;
    end
    if (r.ready && ready_tally != CNT_MAX)
      ready_tally++;
    r.cnt      = ready_tally;
    r.pass_end = lst;
    if (lst) begin
      pass_pos    = 0;
      ready_tally = '0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pass_pos    = 0;
      ready_tally = '0;
      win_limit   = WLIM_RESET;
    end else begin
      if (out_valid && !out_stall) begin
        if (readiness_q.size() == 0) begin
          report_mismatch("result item with none expected", 1, 0);
        end else begin
          want = readiness_q.pop_front();
          if (out_ready_res !== want.ready)
            report_mismatch("ready_res", int'(out_ready_res), int'(want.ready));
          if (out_position !== want.pos)
            report_mismatch("position", int'(out_position), int'(want.pos));
          if (out_within_window !== want.win)
            report_mismatch("within_window", int'(out_within_window),
                            int'(want.win));
          if (out_ready_count !== want.cnt)
            report_mismatch("ready_count", int'(out_ready_count), int'(want.cnt));
          if (out_pass_end !== want.pass_end)
            report_mismatch("pass_end", int'(out_pass_end), int'(want.pass_end));
        end
      end
      if (in_valid && !in_stall) begin
        if (erwc_op_t'(in_op) == OP_LIMIT_WR)
          limit_tbl[{in_earlier_type, in_later_type}] = in_limit_value;
        else
          readiness_q = {readiness_q, predict_event(in_event_time, in_event_type,
                                                    in_event_idle, in_last)};
      end
      if (cfg_valid && cfg_ready)
        win_limit = cfg_window_limit;
    end
    outstanding <= readiness_q.size();
  end

endmodule

[tb/tb_event_readiness_window_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_event_readiness_window_check
// Loads the type-pair limit table, runs directed events over the time and
// window corner cases, then random passes under several window limits with
// random gaps on the item side and random stalls on the result side.
// Checking is done by erwc_readiness_checker beside the block.
// ----------------------------------------------------------------------------
module tb_event_readiness_window_check;
  import erwc_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 135;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_op = 1'b0;
  logic [TYPE_W-1:0]     in_earlier_type = '0;
  logic [TYPE_W-1:0]     in_later_type = '0;
  logic [TIME_WIDTH-1:0] in_limit_value = '0;
  logic [TIME_WIDTH-1:0] in_event_time = '0;
  logic [TYPE_W-1:0]     in_event_type = '0;
  logic                  in_event_idle = 1'b0;
  logic                  in_last = 1'b0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_ready_res;
  logic [OPOS_W-1:0]     out_position;
  logic                  out_within_window;
  logic [CNT_W-1:0]      out_ready_count;
  logic                  out_pass_end;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [WLIM_W-1:0]     cfg_window_limit = '0;

  int                    fail_count;
  int                    outstanding;

  int                    steady_items = 0;
  int                    calm_cycles = 0;
  int                    stall_cycles = 0;
  int unsigned           stall_pick;

  always #1 clk = ~clk;

  event_readiness_window_check DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_earlier_type   (in_earlier_type),
    .in_later_type     (in_later_type),
    .in_limit_value    (in_limit_value),
    .in_event_time     (in_event_time),
    .in_event_type     (in_event_type),
    .in_event_idle     (in_event_idle),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ready_res     (out_ready_res),
    .out_position      (out_position),
    .out_within_window (out_within_window),
    .out_ready_count   (out_ready_count),
    .out_pass_end      (out_pass_end),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_window_limit  (cfg_window_limit)
  );

  erwc_readiness_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_earlier_type   (in_earlier_type),
    .in_later_type     (in_later_type),
    .in_limit_value    (in_limit_value),
    .in_event_time     (in_event_time),
    .in_event_type     (in_event_type),
    .in_event_idle     (in_event_idle),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ready_res     (out_ready_res),
    .out_position      (out_position),
    .out_within_window (out_within_window),
    .out_ready_count   (out_ready_count),
    .out_pass_end      (out_pass_end),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_window_limit  (cfg_window_limit),
    .fail_count        (fail_count),
    .outstanding       (outstanding)
  );

  // result side back-pressure: short stalls, a few long ones, calm stretches
  always @(posedge clk) begin
    if (calm_cycles != 0) begin
      calm_cycles <= calm_cycles - 1;
      out_stall   <= 1'b0;
    end else if (stall_cycles != 0) begin
      stall_cycles <= stall_cycles - 1;
      out_stall    <= 1'b1;
    end else begin
      stall_pick = $urandom_range(0, 999);
      if (stall_pick < 5)
        calm_cycles <= $urandom_range(100, 400);
      else if (stall_pick < 15)
        stall_cycles <= $urandom_range(10, 40);
      else if (stall_pick < 300)
        stall_cycles <= $urandom_range(1, 3);
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(erwc_op_t op, logic [TYPE_W-1:0] et, logic [TYPE_W-1:0] lt,
                           logic [TIME_WIDTH-1:0] lim, logic [TIME_WIDTH-1:0] t,
                           logic [TYPE_W-1:0] ty, logic idle, logic lst);
    int gap;
    int pick;
    gap = 0;
    in_valid        <= 1'b1;
    in_op           <= op;
    in_earlier_type <= et;
    in_later_type   <= lt;
    in_limit_value  <= lim;
    in_event_time   <= t;
    in_event_type   <= ty;
    in_event_idle   <= idle;
    in_last         <= lst;
    do @(posedge clk); while (in_stall);
    if (steady_items != 0) begin
      steady_items--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 3)
        steady_items = $urandom_range(20, 60);
      else if (pick >= 55 && pick < 92)
        gap = $urandom_range(1, 3);
      else if (pick >= 92)
        gap = $urandom_range(8, 40);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_limit(logic [TYPE_W-1:0] et, logic [TYPE_W-1:0] lt,
                             logic [TIME_WIDTH-1:0] lim, logic lst);
    send_item(OP_LIMIT_WR, et, lt, lim, $urandom, TYPE_W'($urandom), 1'($urandom), lst);
  endtask

  task automatic send_event(logic [TIME_WIDTH-1:0] t, logic [TYPE_W-1:0] ty,
                            logic idle, logic lst);
    send_item(OP_EVENT, TYPE_W'($urandom), TYPE_W'($urandom), $urandom, t, ty, idle, lst);
  endtask

  function automatic logic [TIME_WIDTH-1:0] pick_limit();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      return $urandom_range(0, 32'h0004_0000);
    else if (pick < 80)
      return '0;
    else if (pick < 90)
      return '1;
    return $urandom;
  endfunction

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(logic [WLIM_W-1:0] wl);
    wait_for_results();
    cfg_valid        <= 1'b1;
    cfg_window_limit <= wl;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // one pass of mostly nondecreasing times, occasionally left without a last
  task automatic run_pass(int len);
    logic [TIME_WIDTH-1:0] t;
    int                    pick;
    int                    k;
    logic                  cut;
    cut = ($urandom_range(0, 9) == 0);
    t = ($urandom_range(0, 9) == 0) ? TIME_WIDTH'($urandom)
                                    : TIME_WIDTH'($urandom_range(0, 32'h00FF_FFFF));
    for (k = 0; k < len; k++) begin
      send_event(t, TYPE_W'($urandom), ($urandom_range(0, 3) != 0),
                 (k == len - 1) && !cut);
      pick = $urandom_range(0, 99);
      if (pick < 60)
        t = t + $urandom_range(0, 32'h0002_0000);
      else if (pick < 85)
        t = t;
      else if (pick < 95)
        t = t + $urandom_range(0, 32'h00FF_FFFF);
      else
        t = t - $urandom_range(1, 32'h0001_0000);
    end
  endtask

  task automatic random_phase(int n_items);
    int sent;
    int pick;
    int len;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        write_limit(TYPE_W'($urandom), TYPE_W'($urandom), pick_limit(), 1'($urandom));
        sent++;
      end else if (pick < 12) begin
        send_event($urandom, TYPE_W'($urandom), 1'($urandom), 1'($urandom));
        sent++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 80)
          len = $urandom_range(1, 10);
        else if (pick < 95)
          len = $urandom_range(11, 31);
        else
          len = $urandom_range(32, 40);
        run_pass(len);
        sent += len;
      end
      if ($urandom_range(0, 99) == 0)
        wait_for_results();
    end
  endtask

  initial begin
    int et;
    int lt;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // full table first, zero at one corner and all ones at the other
    for (et = 0; et < NUM_TYPES; et++) begin
      for (lt = 0; lt < NUM_TYPES; lt++) begin
        if (et == 0 && lt == 0)
          write_limit(TYPE_W'(et), TYPE_W'(lt), '0, 1'b0);
        else if (et == NUM_TYPES - 1 && lt == NUM_TYPES - 1)
          write_limit(TYPE_W'(et), TYPE_W'(lt), '1, 1'b1);
        else
          write_limit(TYPE_W'(et), TYPE_W'(lt),
                      TIME_WIDTH'($urandom_range(32'h0000_8000, 32'h0003_0000)), 1'b0);
      end
    end

    // zero time, equal time under zero limit, max time, time going back,
    // non-idle event, single-event pass
    send_event('0, 2'd0, 1'b1, 1'b0);
    send_event('0, 2'd0, 1'b1, 1'b0);
    send_event('1, 2'd3, 1'b1, 1'b0);
    send_event(32'h0001_0000, 2'd3, 1'b1, 1'b0);
    send_event(32'h0001_0000, 2'd1, 1'b0, 1'b0);
    send_event(32'h0002_0000, 2'd2, 1'b1, 1'b1);
    send_event($urandom, TYPE_W'($urandom), 1'b1, 1'b1);

    set_window(6'd1);
    random_phase(PHASE_ITEMS);
    set_window(6'd0);
    random_phase(PHASE_ITEMS);
    set_window(6'd63);
    random_phase(PHASE_ITEMS);
    set_window(6'd5);
    random_phase(PHASE_ITEMS);
    set_window(6'd40);
    random_phase(PHASE_ITEMS);
    set_window(6'd32);
    random_phase(PHASE_ITEMS);
    set_window(WLIM_W'($urandom_range(0, 63)));
    random_phase(PHASE_ITEMS);
    set_window(WLIM_W'($urandom_range(1, 32)));
    random_phase(PHASE_ITEMS);

    wait_for_results();
    if (fail_count == 0 && outstanding == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
